// File: sv/met_pkg.sv
package met_pkg;

  localparam int FRAC_BITS_DEF = 28;

  localparam int PORT_W = 32;
  localparam int ITER_W = 16;
  localparam int ZW     = 36;
  localparam int ZH     = ZW / 2;
  localparam int MW     = ZW + ZH + 1;
  localparam int PW     = 2 * ZW;
  localparam int SW     = PW + 2;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_START_REAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_IMAG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_COLOR = 2'd3;

  localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd150;

endpackage

// File: sv/mandelbrot_escape_time_core.sv
// Escape-time engine for one point of the Mandelbrot set per beat.
// Input beat: in_tdata carries c_real in bits [31:0] and c_imag in bits [63:32],
// both signed fixed point with FRAC_BITS fraction bits. Output beat: out_tdata
// carries the 16-bit color, which is the escape count, or inside_color when
// the count reached max_iter (a max_iter of 0 answers inside_color at once).
// Configuration: cfg_we with cfg_addr 0..3 writes start_real, start_imag,
// max_iter and inside_color; write only while no point is in flight.
// One point is worked at a time; in_tready is high only when the engine idles.
// Every product goes through one shared 36x19 multiplier in three phases
// (low half, high half, sum), so each iteration of z = z*z + c steps through
// x*y, update, x*x, y*y, magnitude compare. A point stops when |z|^2 reaches
// 4, when its count reaches max_iter or when z saturates; out_tvalid then
// rises, and the next input beat can be taken in the same cycle that it rises.
// The finished color sits in an output register; a new point is accepted while
// it waits, and the engine holds its own next result until out_tready frees it.
// Reset (rst_n low, synchronous) drops any point in flight, clears out_tvalid
// and restores start_real = start_imag = 0, max_iter = 150, inside_color = 0.
module mandelbrot_escape_time_core #(
  parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [2*met_pkg::PORT_W-1:0]      in_tdata,   // c_real, c_imag
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [met_pkg::ITER_W-1:0]        out_tdata,  // color
  input  logic                              cfg_we,
  input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [met_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int ZW = met_pkg::ZW;
  localparam int ZH = met_pkg::ZH;
  localparam int MW = met_pkg::MW;
  localparam int PW = met_pkg::PW;
  localparam int SW = met_pkg::SW;
  localparam int PORT_W = met_pkg::PORT_W;
  localparam int ITER_W = met_pkg::ITER_W;

  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_SUM = 2'd2;

  localparam logic signed [SW-1:0] FOUR = SW'(4) <<< FRAC_BITS;
  localparam logic signed [SW-1:0] ZMAX = {{(SW-ZW+1){1'b0}}, {(ZW-1){1'b1}}};
  localparam logic signed [SW-1:0] ZMIN = ~ZMAX;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SQX  = 7'b0000010,
    ST_SQY  = 7'b0000100,
    ST_CRS  = 7'b0001000,
    ST_UPD  = 7'b0010000,
    ST_CHK  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic first_r, first_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [ITER_W-1:0] out_color_r, out_color_nxt;

  logic signed [PORT_W-1:0] start_real_r, start_imag_r;
  logic [ITER_W-1:0] max_iter_r, inside_color_r;

  logic signed [ZW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [PORT_W-1:0] cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [PW-1:0] xx_r, xx_nxt, yy_r, yy_nxt, xy_r, xy_nxt;
  logic signed [MW-1:0] pp_r, pp_nxt, lo_r, lo_nxt;
  logic [ITER_W-1:0] count_r, count_nxt;

  logic signed [ZW-1:0] op_a, op_b;
  logic signed [ZH:0] b_part;
  logic signed [MW-1:0] mul;
  logic signed [PW-1:0] lo_ext, hi_ext, prod, prod_sh;
  logic signed [SW-1:0] xx_e, yy_e, xy_e, cr_e, ci_e, nr_w, ni_w, mag_w;
  logic nr_hi, nr_lo, ni_hi, ni_lo, over;
  logic [ITER_W-1:0] count_inc;
  logic in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_color_r;

  assign op_a   = (state_r == ST_SQY) ? y_r : x_r;
  assign op_b   = (state_r == ST_SQX) ? x_r : y_r;
  assign b_part = (ph_r == PH_LO) ? $signed({1'b0, op_b[ZH-1:0]})
                                  : $signed({op_b[ZW-1], op_b[ZW-1:ZH]});
  assign mul    = op_a * b_part;

  assign lo_ext  = {{(PW-MW){lo_r[MW-1]}}, lo_r};
  assign hi_ext  = {{(PW-MW){pp_r[MW-1]}}, pp_r};
  assign prod    = lo_ext + (hi_ext <<< ZH);
  assign prod_sh = (state_r == ST_CRS) ? (prod >>> (FRAC_BITS - 1)) : (prod >>> FRAC_BITS);

  assign xx_e  = {{(SW-PW){xx_r[PW-1]}}, xx_r};
  assign yy_e  = {{(SW-PW){yy_r[PW-1]}}, yy_r};
  assign xy_e  = {{(SW-PW){xy_r[PW-1]}}, xy_r};
  assign cr_e  = {{(SW-PORT_W){cr_r[PORT_W-1]}}, cr_r};
  assign ci_e  = {{(SW-PORT_W){ci_r[PORT_W-1]}}, ci_r};
  assign nr_w  = xx_e - yy_e + cr_e;
  assign ni_w  = xy_e + ci_e;
  assign mag_w = xx_e + yy_e;
  assign nr_hi = nr_w > ZMAX;
  assign nr_lo = nr_w < ZMIN;
  assign ni_hi = ni_w > ZMAX;
  assign ni_lo = ni_w < ZMIN;
  assign over  = nr_hi || nr_lo || ni_hi || ni_lo;
  assign count_inc = count_r + 16'd1;

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r;
    out_color_nxt = out_color_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    xx_nxt        = xx_r;
    yy_nxt        = yy_r;
    xy_nxt        = xy_r;
    pp_nxt        = pp_r;
    lo_nxt        = lo_r;
    count_nxt     = count_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_nxt     = {{(ZW-PORT_W){start_real_r[PORT_W-1]}}, start_real_r};
          y_nxt     = {{(ZW-PORT_W){start_imag_r[PORT_W-1]}}, start_imag_r};
          cr_nxt    = in_tdata[PORT_W-1:0];
          ci_nxt    = in_tdata[2*PORT_W-1:PORT_W];
          count_nxt = '0;
          first_nxt = 1'b1;
          ph_nxt    = PH_LO;
          state_nxt = (max_iter_r == '0) ? ST_DONE : ST_SQX;
        end
      end
      ST_SQX, ST_SQY, ST_CRS: begin
        case (ph_r)
          PH_LO: begin
            pp_nxt = mul;
            ph_nxt = PH_HI;
          end
          PH_HI: begin
            lo_nxt = pp_r;
            pp_nxt = mul;
            ph_nxt = PH_SUM;
          end
          default: begin
            ph_nxt = PH_LO;
            if (state_r == ST_SQX) begin
              xx_nxt    = prod_sh;
              state_nxt = ST_SQY;
            end else if (state_r == ST_SQY) begin
              yy_nxt    = prod_sh;
              state_nxt = first_r ? ST_CRS : ST_CHK;
            end else begin
              xy_nxt    = prod_sh;
              state_nxt = ST_UPD;
            end
          end
        endcase
      end
      ST_UPD: begin
        first_nxt = 1'b0;
        count_nxt = count_inc;
        x_nxt = nr_hi ? ZMAX[ZW-1:0] : (nr_lo ? ZMIN[ZW-1:0] : nr_w[ZW-1:0]);
        y_nxt = ni_hi ? ZMAX[ZW-1:0] : (ni_lo ? ZMIN[ZW-1:0] : ni_w[ZW-1:0]);
        state_nxt = (over || count_inc >= max_iter_r) ? ST_DONE : ST_SQX;
      end
      ST_CHK: begin
        state_nxt = (mag_w >= FOUR) ? ST_DONE : ST_CRS;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = (count_r >= max_iter_r) ? inside_color_r : count_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      ph_r           <= PH_LO;
      first_r        <= 1'b0;
      out_valid_r    <= 1'b0;
      start_real_r   <= '0;
      start_imag_r   <= '0;
      max_iter_r     <= met_pkg::MAX_ITER_RST;
      inside_color_r <= '0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          met_pkg::CFG_START_REAL:   start_real_r   <= cfg_wdata[PORT_W-1:0];
          met_pkg::CFG_START_IMAG:   start_imag_r   <= cfg_wdata[PORT_W-1:0];
          met_pkg::CFG_MAX_ITER:     max_iter_r     <= cfg_wdata[ITER_W-1:0];
          met_pkg::CFG_INSIDE_COLOR: inside_color_r <= cfg_wdata[ITER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_color_r <= out_color_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    cr_r        <= cr_nxt;
    ci_r        <= ci_nxt;
    xx_r        <= xx_nxt;
    yy_r        <= yy_nxt;
    xy_r        <= xy_nxt;
    pp_r        <= pp_nxt;
    lo_r        <= lo_nxt;
    count_r     <= count_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("engine still ready after taking a point");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) && !(state_r == ST_DONE) && (state_r != ST_UPD)
      |-> count_r < max_iter_r)
    else $error("iteration count passed the limit");

  a_square_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQX) && (ph_r == PH_SUM) |=> !xx_r[PW-1])
    else $error("x squared came out negative");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) || (state_r == ST_CHK) || (state_r == ST_IDLE)
      |-> ph_r == PH_LO)
    else $error("multiplier phase left mid-product");

endmodule
